### hw/rtl/pst_pkg.sv
// shared types, constants and keyword table for the tokenizer
package pst_pkg;

  localparam int OFFSET_BITS       = 24;
  localparam int LENGTH_BITS       = 16;
  localparam int KEYWORD_COUNT     = 28;
  localparam int KEYWORD_MAX_CHARS = 9;
  localparam int KW_POS_BITS       = $clog2(KEYWORD_MAX_CHARS + 1);
  localparam logic [LENGTH_BITS-1:0] LEN_MAX = {LENGTH_BITS{1'b1}};
  localparam logic [15:0] NUMBER_LIMIT_RESET = 16'd32767;
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_BITS  = $clog2(QUEUE_DEPTH);

  localparam logic [5:0] K_NAME    = 6'(KEYWORD_COUNT + 0);
  localparam logic [5:0] K_NUMBER  = 6'(KEYWORD_COUNT + 1);
  localparam logic [5:0] K_STRING  = 6'(KEYWORD_COUNT + 2);
  localparam logic [5:0] K_PLUS    = 6'(KEYWORD_COUNT + 3);
  localparam logic [5:0] K_MINUS   = 6'(KEYWORD_COUNT + 4);
  localparam logic [5:0] K_STAR    = 6'(KEYWORD_COUNT + 5);
  localparam logic [5:0] K_EQUAL   = 6'(KEYWORD_COUNT + 6);
  localparam logic [5:0] K_NOTEQ   = 6'(KEYWORD_COUNT + 7);
  localparam logic [5:0] K_LE      = 6'(KEYWORD_COUNT + 8);
  localparam logic [5:0] K_LEEQ    = 6'(KEYWORD_COUNT + 9);
  localparam logic [5:0] K_GR      = 6'(KEYWORD_COUNT + 10);
  localparam logic [5:0] K_GREQ    = 6'(KEYWORD_COUNT + 11);
  localparam logic [5:0] K_LPAREN  = 6'(KEYWORD_COUNT + 12);
  localparam logic [5:0] K_RPAREN  = 6'(KEYWORD_COUNT + 13);
  localparam logic [5:0] K_LSQ     = 6'(KEYWORD_COUNT + 14);
  localparam logic [5:0] K_RSQ     = 6'(KEYWORD_COUNT + 15);
  localparam logic [5:0] K_ASSIGN  = 6'(KEYWORD_COUNT + 16);
  localparam logic [5:0] K_DOT     = 6'(KEYWORD_COUNT + 17);
  localparam logic [5:0] K_COMMA   = 6'(KEYWORD_COUNT + 18);
  localparam logic [5:0] K_COLON   = 6'(KEYWORD_COUNT + 19);
  localparam logic [5:0] K_SEMI    = 6'(KEYWORD_COUNT + 20);
  localparam logic [5:0] K_SPACE   = 6'(KEYWORD_COUNT + 21);
  localparam logic [5:0] K_BRACE   = 6'(KEYWORD_COUNT + 22);
  localparam logic [5:0] K_CSTYLE  = 6'(KEYWORD_COUNT + 23);
  localparam logic [5:0] K_EOF     = 6'(KEYWORD_COUNT + 24);
  localparam logic [5:0] K_UNKNOWN = 6'(KEYWORD_COUNT + 25);
  localparam logic [5:0] K_ERROR   = 6'(KEYWORD_COUNT + 26);

  localparam logic [2:0] E_NONE    = 3'd0;
  localparam logic [2:0] E_TOOBIG  = 3'd1;
  localparam logic [2:0] E_UNTERM  = 3'd2;
  localparam logic [2:0] E_NONGRAPH = 3'd3;
  localparam logic [2:0] E_STRAY   = 3'd4;

  // lexer modes
  localparam logic [3:0] M_IDLE   = 4'd0;
  localparam logic [3:0] M_SPACE  = 4'd1;
  localparam logic [3:0] M_BRACE  = 4'd2;
  localparam logic [3:0] M_SLASH  = 4'd3;
  localparam logic [3:0] M_CBODY  = 4'd4;
  localparam logic [3:0] M_CSTAR  = 4'd5;
  localparam logic [3:0] M_STRING = 4'd6;
  localparam logic [3:0] M_SQUOTE = 4'd7;
  localparam logic [3:0] M_NAME   = 4'd8;
  localparam logic [3:0] M_NUMBER = 4'd9;
  localparam logic [3:0] M_LT     = 4'd10;
  localparam logic [3:0] M_GT     = 4'd11;
  localparam logic [3:0] M_COLON  = 4'd12;

  typedef logic [KEYWORD_COUNT-1:0] kw_mask_t;

  // one classified input item from the front part
  typedef struct packed {
    logic [7:0] ch;
    logic       eoi;
    logic       is_ws;
    logic       is_graph;
    logic       is_letter;
    logic       is_digit;
    logic [OFFSET_BITS-1:0] offset;
  } item_t;

  // one result token
  typedef struct packed {
    logic [5:0]  token_kind;
    logic [23:0] start_offset;
    logic [15:0] token_length;
    logic [14:0] number_value;
    logic [15:0] raw_text_length;
    logic [15:0] text_length;
    logic [2:0]  error_code;
    logic        last_of_run;
  } token_t;

  function automatic logic [7:0] kw_char(input int k, input int p);
    string s;
    s = "";
    case (k)
      0: s = "program";   1: s = "var";      2: s = "array";   3: s = "of";
      4: s = "begin";     5: s = "end";      6: s = "if";      7: s = "then";
      8: s = "else";      9: s = "procedure"; 10: s = "return"; 11: s = "call";
      12: s = "while";    13: s = "do";      14: s = "not";    15: s = "or";
      16: s = "div";      17: s = "and";     18: s = "char";   19: s = "integer";
      20: s = "boolean";  21: s = "read";    22: s = "write";  23: s = "readln";
      24: s = "writeln";  25: s = "true";    26: s = "false";  27: s = "break";
      default: s = "";
    endcase
    if (p < s.len()) begin
      return s[p];
    end
    return 8'h00;
  endfunction

endpackage

### hw/rtl/pst_if.sv
// valid/ready channel interfaces for bytes, tokens and configuration
interface pst_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] source_byte;
  logic       end_of_input;
  modport source (output valid, source_byte, end_of_input, input ready);
  modport sink (input valid, source_byte, end_of_input, output ready);
endinterface

interface pst_token_if;
  logic        valid;
  logic        ready;
  logic [5:0]  token_kind;
  logic [23:0] start_offset;
  logic [15:0] token_length;
  logic [14:0] number_value;
  logic [15:0] raw_text_length;
  logic [15:0] text_length;
  logic [2:0]  error_code;
  logic        last_of_run;
  modport source (output valid, token_kind, start_offset, token_length, number_value,
                  raw_text_length, text_length, error_code, last_of_run, input ready);
  modport sink (input valid, token_kind, start_offset, token_length, number_value,
                raw_text_length, text_length, error_code, last_of_run, output ready);
endinterface

interface pst_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

### hw/rtl/pascal_subset_tokenizer.sv
// top level of the streaming pascal subset tokenizer
//
// channels: in_if moves one source byte or an end-of-input mark per
// transfer; out_if moves one token per transfer; cfg_if writes the
// number limit (reset 32767) and is always ready.
// an item moves from the input through a four-entry classification
// queue to the lexer; at most two tokens per item land in a two-entry
// output buffer. an item is registered in the queue, and its first token
// is registered in the output buffer when the lexer takes the item.
// throughput: one byte per cycle while out_if is ready, set by the
// combinational lexer step; an item that yields two tokens holds the
// lexer while the output buffer drains.
// reset clears the queue, offsets and lexer state; after end of input
// bytes are taken and dropped until the next reset.
// when the receiver stalls, the lexer stops with a token buffered and
// the queue absorbs up to four more bytes before in_if drops ready.
module pascal_subset_tokenizer (
  input  logic        clk_i,
  input  logic        rst_ni,
  pst_byte_if.sink    in_if,
  pst_cfg_if.sink     cfg_if,
  pst_token_if.source out_if
);
  import pst_pkg::*;

  item_t       item;
  logic        item_valid, item_ready, idle;
  logic [15:0] limit_q;

  assign cfg_if.ready = 1'b1;

  // number limit register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= NUMBER_LIMIT_RESET;
    end else if (cfg_if.valid) begin
      limit_q <= cfg_if.data;
    end
  end

  pst_front u_front (
    .clk_i, .rst_ni, .in_if,
    .item_o(item), .item_valid_o(item_valid), .item_ready_i(item_ready)
  );

  pst_back u_back (
    .clk_i, .rst_ni, .item_i(item), .item_valid_i(item_valid),
    .item_ready_o(item_ready), .number_limit_i(limit_q), .idle_o(idle), .out_if
  );

  // output tokens never report kinds beyond the error code
  a_kind_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid |-> out_if.token_kind <= K_ERROR)
    else $error("token kind out of range");

  // eof tokens carry zero length
  a_eof_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_if.valid && out_if.token_kind == K_EOF) |-> out_if.token_length == '0)
    else $error("eof with nonzero length");

  // stalled output token holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_if.valid && !out_if.ready) |=> (out_if.valid && $stable(out_if.token_kind)))
    else $error("output token changed under stall");

  // lexer idle means no token waiting
  a_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idle |-> !out_if.valid)
    else $error("idle with token waiting");
endmodule

### hw/rtl/pst_front.sv
// front part: accepts bytes, classifies them, tags offsets, queues them
module pst_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  pst_byte_if.sink       in_if,
  output pst_pkg::item_t item_o,
  output logic           item_valid_o,
  input  logic           item_ready_i
);
  import pst_pkg::*;

  item_t               mem_q [QUEUE_DEPTH];
  logic [QUEUE_BITS:0] wr_q, wr_d, rd_q, rd_d;
  logic [OFFSET_BITS-1:0] off_q, off_d;
  logic                done_q, done_d;
  logic                full, push, pop;
  item_t               cls;
  logic [7:0]          c;

  assign full  = (wr_q[QUEUE_BITS] != rd_q[QUEUE_BITS]) &&
                 (wr_q[QUEUE_BITS-1:0] == rd_q[QUEUE_BITS-1:0]);
  // after end of input all items are swallowed
  assign in_if.ready = !full || done_q;
  assign push = in_if.valid && in_if.ready && !done_q;
  assign item_valid_o = wr_q != rd_q;
  assign pop = item_valid_o && item_ready_i;
  assign item_o = mem_q[rd_q[QUEUE_BITS-1:0]];

  always_comb begin
    c = in_if.source_byte;
    cls.ch        = c;
    cls.eoi       = in_if.end_of_input;
    cls.is_ws     = (c == 8'h20) || (c == 8'h09) || (c == 8'h0A) || (c == 8'h0D);
    cls.is_graph  = (c >= 8'h20 && c <= 8'h7E) || (c == 8'h09) || (c == 8'h0A) ||
                    (c == 8'h0D);
    cls.is_letter = (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
    cls.is_digit  = (c >= "0" && c <= "9");
    cls.offset    = off_q;
    wr_d = push ? wr_q + 1'b1 : wr_q;
    rd_d = pop ? rd_q + 1'b1 : rd_q;
    off_d = (push && !in_if.end_of_input) ? off_q + 1'b1 : off_q;
    done_d = done_q || (push && in_if.end_of_input);
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q[QUEUE_BITS-1:0]] <= cls;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q   <= '0;
      rd_q   <= '0;
      off_q  <= '0;
      done_q <= 1'b0;
    end else begin
      wr_q   <= wr_d;
      rd_q   <= rd_d;
      off_q  <= off_d;
      done_q <= done_d;
    end
  end
endmodule

### hw/rtl/pst_back.sv
// back part: lexer state machine, emits up to two tokens per item
module pst_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  pst_pkg::item_t item_i,
  input  logic           item_valid_i,
  output logic           item_ready_o,
  input  logic [15:0]    number_limit_i,
  output logic           idle_o,
  pst_token_if.source    out_if
);
  import pst_pkg::*;

  logic [3:0]             mode_q, mode_d;
  logic [OFFSET_BITS-1:0] start_q, start_d;
  logic [LENGTH_BITS-1:0] len_q, len_d, logc_q, logc_d;
  logic [15:0]            acc_q, acc_d;
  logic                   ovf_q, ovf_d;
  kw_mask_t               kw_q, kw_d;

  // two-entry output buffer, head in entry 0
  token_t  ob_q [2];
  logic [1:0] ocnt_q, ocnt_d;

  token_t     t0, t1;
  logic       v0, v1;
  logic       take, pop;
  logic       consumed;
  logic [19:0] mul10;
  logic [5:0]  nkind;
  kw_mask_t    kw_filt, kw_filt0;
  logic [LENGTH_BITS-1:0] len_inc;

  assign item_ready_o = (ocnt_q == 2'd0) || (ocnt_q == 2'd1 && out_if.ready);
  assign take = item_valid_i && item_ready_o;
  assign pop  = out_if.valid && out_if.ready;
  assign idle_o = (ocnt_q == 2'd0) && !item_valid_i;
  assign len_inc = (len_q == LEN_MAX) ? len_q : len_q + 1'b1;

  always_comb begin
    for (int k = 0; k < KEYWORD_COUNT; k++) begin
      kw_filt[k] = kw_q[k] && (len_q < LENGTH_BITS'(KEYWORD_MAX_CHARS)) &&
                   (kw_char(k, int'(len_q[KW_POS_BITS-1:0])) == item_i.ch);
      kw_filt0[k] = kw_char(k, 0) == item_i.ch;
    end
    nkind = K_NAME;
    if (len_q <= LENGTH_BITS'(KEYWORD_MAX_CHARS)) begin
      for (int k = KEYWORD_COUNT - 1; k >= 0; k--) begin
        if (kw_q[k] && kw_char(k, int'(len_q[KW_POS_BITS-1:0])) == 8'h00) begin
          nkind = 6'(k);
        end
      end
    end
  end

  function automatic token_t mk(input logic [5:0] kind, input logic [23:0] st,
                                input logic [15:0] ln, input logic [14:0] num,
                                input logic [15:0] raw, input logic [15:0] txt,
                                input logic [2:0] err);
    token_t t;
    t.token_kind = kind; t.start_offset = st; t.token_length = ln;
    t.number_value = num; t.raw_text_length = raw; t.text_length = txt;
    t.error_code = err; t.last_of_run = 1'b0;
    return t;
  endfunction

  always_comb begin
    logic [2:0] bad;
    logic [16:0] nxt;
    logic [5:0]  sk;
    mode_d = mode_q; start_d = start_q; len_d = len_q; logc_d = logc_q;
    acc_d = acc_q; ovf_d = ovf_q; kw_d = kw_q;
    v0 = 1'b0; v1 = 1'b0; t0 = '0; t1 = '0;
    consumed = 1'b0;
    bad = item_i.eoi ? E_UNTERM : E_NONGRAPH;
    mul10 = {1'b0, acc_q, 3'b000} + {3'b000, acc_q, 1'b0};
    nxt = 17'd0;
    sk = K_UNKNOWN;
    if (take) begin
      // try to extend the pending token
      if (!item_i.eoi) begin
        unique case (mode_q)
          M_SPACE: if (item_i.is_ws) begin len_d = len_inc; consumed = 1'b1; end
          M_BRACE: if (item_i.ch == "}") begin
            v0 = 1'b1; t0 = mk(K_BRACE, start_q, len_inc, '0, '0, '0, E_NONE);
            mode_d = M_IDLE; consumed = 1'b1;
          end else if (item_i.is_graph) begin len_d = len_inc; consumed = 1'b1; end
          M_SLASH: if (item_i.ch == "*") begin
            len_d = len_inc; mode_d = M_CBODY; consumed = 1'b1;
          end
          M_CBODY, M_CSTAR: if (mode_q == M_CSTAR && item_i.ch == "/") begin
            v0 = 1'b1; t0 = mk(K_CSTYLE, start_q, len_inc, '0, '0, '0, E_NONE);
            mode_d = M_IDLE; consumed = 1'b1;
          end else if (item_i.is_graph) begin
            len_d = len_inc; consumed = 1'b1;
            mode_d = (item_i.ch == "*") ? M_CSTAR : M_CBODY;
          end
          M_STRING: if (item_i.ch == "'") begin
            len_d = len_inc; mode_d = M_SQUOTE; consumed = 1'b1;
          end else if (item_i.is_graph && item_i.ch != 8'h0A && item_i.ch != 8'h0D) begin
            len_d = len_inc; consumed = 1'b1;
            logc_d = (logc_q == LEN_MAX) ? logc_q : logc_q + 1'b1;
          end
          M_SQUOTE: if (item_i.ch == "'") begin
            len_d = len_inc; mode_d = M_STRING; consumed = 1'b1;
            logc_d = (logc_q == LEN_MAX) ? logc_q : logc_q + 1'b1;
          end
          M_NAME: if (item_i.is_letter || item_i.is_digit) begin
            kw_d = kw_filt; len_d = len_inc; consumed = 1'b1;
          end
          M_NUMBER: if (item_i.is_digit) begin
            nxt = 17'(mul10) + 17'(item_i.ch - "0");
            if (mul10[19:16] != 4'd0 || nxt[16]) begin
              ovf_d = 1'b1; acc_d = 16'hFFFF;
            end else begin
              acc_d = nxt[15:0];
            end
            len_d = len_inc; consumed = 1'b1;
          end
          M_LT: if (item_i.ch == ">" || item_i.ch == "=") begin
            v0 = 1'b1; mode_d = M_IDLE; consumed = 1'b1;
            t0 = mk((item_i.ch == ">") ? K_NOTEQ : K_LEEQ, start_q, len_inc,
                    '0, '0, '0, E_NONE);
          end
          M_GT: if (item_i.ch == "=") begin
            v0 = 1'b1; t0 = mk(K_GREQ, start_q, len_inc, '0, '0, '0, E_NONE);
            mode_d = M_IDLE; consumed = 1'b1;
          end
          M_COLON: if (item_i.ch == "=") begin
            v0 = 1'b1; t0 = mk(K_ASSIGN, start_q, len_inc, '0, '0, '0, E_NONE);
            mode_d = M_IDLE; consumed = 1'b1;
          end
          default: ;
        endcase
      end
      // flush pending token
      if (!consumed && mode_q != M_IDLE) begin
        v0 = 1'b1;
        unique case (mode_q)
          M_SPACE: t0 = mk(K_SPACE, start_q, len_q, '0, '0, '0, E_NONE);
          M_BRACE, M_CBODY, M_CSTAR, M_STRING:
            t0 = mk(K_ERROR, start_q, len_q, '0, '0, '0, bad);
          M_SLASH: t0 = mk(K_UNKNOWN, start_q, len_q, '0, '0, '0, E_STRAY);
          M_SQUOTE: t0 = mk(K_STRING, start_q, len_q, '0,
                            (len_q >= 16'd2) ? len_q - 16'd2 : '0, logc_q, E_NONE);
          M_NAME: t0 = mk(nkind, start_q, len_q, '0, '0, '0, E_NONE);
          M_NUMBER: if (ovf_q || acc_q > number_limit_i) begin
            t0 = mk(K_ERROR, start_q, len_q, '0, '0, '0, E_TOOBIG);
          end else begin
            t0 = mk(K_NUMBER, start_q, len_q, acc_q[14:0], '0, '0, E_NONE);
          end
          M_LT: t0 = mk(K_LE, start_q, len_q, '0, '0, '0, E_NONE);
          M_GT: t0 = mk(K_GR, start_q, len_q, '0, '0, '0, E_NONE);
          M_COLON: t0 = mk(K_COLON, start_q, len_q, '0, '0, '0, E_NONE);
          default: t0 = '0;
        endcase
        mode_d = M_IDLE;
      end
      if (item_i.eoi) begin
        v1 = 1'b1;
        t1 = mk(K_EOF, item_i.offset, '0, '0, '0, '0, E_NONE);
        start_d = item_i.offset; len_d = '0;
      end else if (!consumed) begin
        // start a new token
        start_d = item_i.offset; len_d = LENGTH_BITS'(1); logc_d = '0;
        acc_d = '0; ovf_d = 1'b0; kw_d = '1; mode_d = M_IDLE;
        if (item_i.is_ws) begin
          mode_d = M_SPACE;
        end else if (item_i.is_letter) begin
          kw_d = kw_filt0; mode_d = M_NAME;
        end else if (item_i.is_digit) begin
          acc_d = 16'(item_i.ch - "0"); mode_d = M_NUMBER;
        end else begin
          v1 = 1'b1;
          unique case (item_i.ch)
            "{": begin mode_d = M_BRACE; v1 = 1'b0; end
            "/": begin mode_d = M_SLASH; v1 = 1'b0; end
            "'": begin mode_d = M_STRING; v1 = 1'b0; end
            "<": begin mode_d = M_LT; v1 = 1'b0; end
            ">": begin mode_d = M_GT; v1 = 1'b0; end
            ":": begin mode_d = M_COLON; v1 = 1'b0; end
            "+": sk = K_PLUS;
            "-": sk = K_MINUS;
            "*": sk = K_STAR;
            "=": sk = K_EQUAL;
            "(": sk = K_LPAREN;
            ")": sk = K_RPAREN;
            "[": sk = K_LSQ;
            "]": sk = K_RSQ;
            ".": sk = K_DOT;
            ",": sk = K_COMMA;
            ";": sk = K_SEMI;
            default: sk = K_UNKNOWN;
          endcase
          t1 = mk(sk, item_i.offset, LENGTH_BITS'(1), '0, '0, '0,
                  (sk == K_UNKNOWN) ? E_STRAY : E_NONE);
        end
      end
      if (v1) t1.last_of_run = 1'b1;
      else if (v0) t0.last_of_run = 1'b1;
    end
  end

  // output buffer: new tokens only land when it drains empty this cycle
  always_comb begin
    ocnt_d = ocnt_q - {1'b0, pop} + {1'b0, v0} + {1'b0, v1};
  end

  always_ff @(posedge clk_i) begin
    if (v0 && v1) begin
      ob_q[0] <= t0;
      ob_q[1] <= t1;
    end else if (v0 || v1) begin
      ob_q[0] <= v0 ? t0 : t1;
    end else if (pop && ocnt_q == 2'd2) begin
      ob_q[0] <= ob_q[1];
    end
  end

  assign out_if.valid           = ocnt_q != 2'd0;
  assign out_if.token_kind      = ob_q[0].token_kind;
  assign out_if.start_offset    = ob_q[0].start_offset;
  assign out_if.token_length    = ob_q[0].token_length;
  assign out_if.number_value    = ob_q[0].number_value;
  assign out_if.raw_text_length = ob_q[0].raw_text_length;
  assign out_if.text_length     = ob_q[0].text_length;
  assign out_if.error_code      = ob_q[0].error_code;
  assign out_if.last_of_run     = ob_q[0].last_of_run;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= M_IDLE; start_q <= '0; len_q <= '0; logc_q <= '0;
      acc_q <= '0; ovf_q <= 1'b0; kw_q <= '1;
      ocnt_q <= '0;
    end else begin
      mode_q <= mode_d; start_q <= start_d; len_q <= len_d; logc_q <= logc_d;
      acc_q <= acc_d; ovf_q <= ovf_d; kw_q <= kw_d;
      ocnt_q <= ocnt_d;
    end
  end
endmodule
